// ===== hdl/image_error_statistics_core_macros.svh =====
// Assertion macros for the image error statistics core.
// Included by the top module, which checks its own pipeline invariants.
`ifndef IMAGE_ERROR_STATISTICS_CORE_MACROS_SVH
`define IMAGE_ERROR_STATISTICS_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IESC_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("iesc assertion failed");

// Next-cycle implication, disabled during reset.
`define IESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("iesc assertion failed");

`endif

// ===== hdl/iesc_pkg.sv =====
// Shared types and constants of the image error statistics core.
// No dependencies; imported by every module of the block.
package iesc_pkg;

	localparam int WINDOW_LEN_DEF     = 8;
	localparam int MAX_LINE_WIDTH_DEF = 8192;
	localparam int LANES              = 3;
	localparam int SAMPLE_W           = 12;
	localparam int SSE_W              = 48;
	localparam int ALARM_W            = 27;
	localparam int LARGE_W            = 26;
	localparam int THR_W              = 12;
	localparam int DIST_W             = 13;
	localparam int CFG_IDX_W          = 2;
	localparam int CFG_DATA_W         = 13;
	localparam int OUT_DEPTH          = 4;

	localparam logic [SAMPLE_W-1:0] LARGE_ERR_LIMIT   = 12'd10;
	localparam logic [THR_W-1:0]    THRESHOLD_RESET   = 12'd10;
	localparam logic [DIST_W-1:0]   DISTANCE_RESET    = 13'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLOR_MODE       = 2'd0,
		CFG_WINDOW_THRESHOLD = 2'd1,
		CFG_ALARM_DISTANCE   = 2'd2
	} iesc_cfg_index_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] ref_lane0;
		logic [SAMPLE_W-1:0] ref_lane1;
		logic [SAMPLE_W-1:0] ref_lane2;
		logic [SAMPLE_W-1:0] test_lane0;
		logic [SAMPLE_W-1:0] test_lane1;
		logic [SAMPLE_W-1:0] test_lane2;
		logic [LANES-1:0]    lane_valid;
		logic                end_of_line;
		logic                end_of_frame;
	} iesc_in_t;

	typedef struct packed {
		logic [SSE_W-1:0]    sse_lane0;
		logic [SSE_W-1:0]    sse_lane1;
		logic [SSE_W-1:0]    sse_lane2;
		logic [SAMPLE_W-1:0] max_err_lane0;
		logic [SAMPLE_W-1:0] max_err_lane1;
		logic [SAMPLE_W-1:0] max_err_lane2;
		logic [ALARM_W-1:0]  window_alarm_count;
		logic [LARGE_W-1:0]  large_error_count;
	} iesc_out_t;

	typedef struct packed {
		logic             rgb;
		logic             line_clear;
		logic [THR_W-1:0] threshold;
	} iesc_lane_ctrl_t;

	typedef struct packed {
		logic alarm;
		logic big;
	} iesc_lane_stat_t;

endpackage

// ===== hdl/iesc_lane.sv =====
// One lane: absolute error, sliding window and alarm test, squared error sum, maximum.
// Depends on iesc_pkg.
module iesc_lane import iesc_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	localparam int SLOT_W = $clog2(WINDOW_LEN),
	localparam int FILL_W = $clog2(WINDOW_LEN + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [SAMPLE_W-1:0]  ref_sample,
	input  logic [SAMPLE_W-1:0]  test_sample,
	input  logic                 ok,
	input  logic                 v_s1,
	input  iesc_lane_ctrl_t      ctrl,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [FILL_W-1:0]    fill,
	input  logic                 v_s2,
	input  logic                 eof_s2,
	output iesc_lane_stat_t      stat_s2,
	output logic [SSE_W-1:0]     sse_next,
	output logic [SAMPLE_W-1:0]  max_next
);

	localparam int SUM_W  = SAMPLE_W + SLOT_W;
	localparam int THRF_W = THR_W + FILL_W;

	logic [SAMPLE_W-1:0]   ae_s1;
	logic                  ok_s1;
	logic [SAMPLE_W-1:0]   store_q [WINDOW_LEN];
	logic [SUM_W-1:0]      sum_q;
	logic [2*SAMPLE_W-1:0] sq_s2;
	logic                  ok_s2;
	logic [SAMPLE_W-1:0]   max_s2;
	logic [SSE_W-1:0]      sse_q;
	logic [SAMPLE_W-1:0]   max_q;

	logic [SAMPLE_W-1:0] ae_in;
	logic [SAMPLE_W-1:0] ae_m;
	logic [SUM_W-1:0]    new_sum;
	logic [THRF_W-1:0]   thr_fill;
	logic                alarm;
	logic [SSE_W:0]      sse_sum;

	assign ae_in    = (test_sample >= ref_sample) ? test_sample - ref_sample
	                                              : ref_sample - test_sample;
	assign ae_m     = ok_s1 ? ae_s1 : '0;
	assign new_sum  = sum_q - SUM_W'(store_q[slot]) + SUM_W'(ae_m);
	assign thr_fill = THRF_W'(ctrl.threshold) * THRF_W'(fill);
	assign alarm    = ctrl.rgb && ok_s1 && (THRF_W'(new_sum) > thr_fill);

	always_ff @(posedge clk) begin
		if (accept) begin
			ae_s1 <= ae_in;
			ok_s1 <= ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) store_q[i] <= '0;
			sum_q <= '0;
		end else if (v_s1) begin
			if (ctrl.line_clear) begin
				for (int i = 0; i < WINDOW_LEN; i++) store_q[i] <= '0;
				sum_q <= '0;
			end else if (ctrl.rgb) begin
				store_q[slot] <= ae_m;
				sum_q         <= new_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sq_s2         <= ae_s1 * ae_s1;
			ok_s2         <= ok_s1;
			max_s2        <= (ctrl.rgb && ok_s1) ? ae_s1 : '0;
			stat_s2.alarm <= alarm;
			stat_s2.big   <= ctrl.rgb && ok_s1 && (ae_s1 > LARGE_ERR_LIMIT);
		end
	end

	assign sse_sum  = {1'b0, sse_q} + (SSE_W+1)'(sq_s2);
	assign sse_next = !ok_s2 ? sse_q : (sse_sum[SSE_W] ? '1 : sse_sum[SSE_W-1:0]);
	assign max_next = (max_s2 > max_q) ? max_s2 : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sse_q <= '0;
			max_q <= '0;
		end else if (v_s2) begin
			sse_q <= eof_s2 ? '0 : sse_next;
			max_q <= eof_s2 ? '0 : max_next;
		end
	end

endmodule

// ===== hdl/iesc_merge.sv =====
// Merge of lane findings: weighted window alarm count and large error count.
// Depends on iesc_pkg.
module iesc_merge import iesc_pkg::*; #(
	parameter int COL_W = $clog2(MAX_LINE_WIDTH_DEF)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                v_s2,
	input  logic                line_end_s2,
	input  logic                eof_s2,
	input  logic [COL_W-1:0]    col_s2,
	input  iesc_lane_stat_t     stat [LANES],
	input  logic [DIST_W-1:0]   alarm_distance,
	output logic [ALARM_W-1:0]  alarm_next,
	output logic [LARGE_W-1:0]  large_next
);

	logic [COL_W-1:0]   last_q;
	logic [ALARM_W-1:0] alarm_q;
	logic [LARGE_W-1:0] large_q;

	logic [COL_W-1:0]   gap;
	logic               first_near;
	logic               rest_near;
	logic [2:0]         inc;
	logic [1:0]         big_cnt;
	logic               any_alarm;
	logic [ALARM_W:0]   alarm_sum;
	logic [LARGE_W:0]   large_sum;

	assign gap        = col_s2 - last_q;
	assign first_near = DIST_W'(gap) < alarm_distance;
	assign rest_near  = alarm_distance != '0;

	always_comb begin
		logic seen;
		seen    = 1'b0;
		inc     = '0;
		big_cnt = '0;
		for (int i = 0; i < LANES; i++) begin
			if (stat[i].alarm) begin
				inc  = inc + ((seen ? rest_near : first_near) ? 3'd2 : 3'd1);
				seen = 1'b1;
			end
			if (stat[i].big) big_cnt = big_cnt + 2'd1;
		end
		any_alarm = seen;
	end

	assign alarm_sum  = {1'b0, alarm_q} + (ALARM_W+1)'(inc);
	assign alarm_next = alarm_sum[ALARM_W] ? '1 : alarm_sum[ALARM_W-1:0];
	assign large_sum  = {1'b0, large_q} + (LARGE_W+1)'(big_cnt);
	assign large_next = large_sum[LARGE_W] ? '1 : large_sum[LARGE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			alarm_q <= '0;
			large_q <= '0;
		end else if (v_s2) begin
			alarm_q <= eof_s2 ? '0 : alarm_next;
			large_q <= eof_s2 ? '0 : large_next;
			if (line_end_s2) last_q <= '0;
			else if (any_alarm) last_q <= col_s2;
		end
	end

endmodule

// ===== hdl/iesc_out_fifo.sv =====
// Result queue between the accumulators and the output channel.
// Depends on iesc_pkg.
module iesc_out_fifo import iesc_pkg::*; #(
	parameter int DEPTH = OUT_DEPTH,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  iesc_out_t        push_data,
	input  logic             pop,
	output logic             out_valid,
	output iesc_out_t        out_data,
	output logic [CNT_W-1:0] count
);

	iesc_out_t        buf_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign out_valid = count_q != '0;
	assign out_data  = buf_q[rd_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hdl/image_error_statistics_core.sv =====
// Output: out_valid rises once a frame-end request accepted here has passed the s1 and s2
// registers and been written into the result queue; out_stall holds the result there.
// Throughput: one pixel per cycle while in_stall is low. in_stall rises once the 4-entry
// result queue plus frame ends in flight fill it.
// Reset: arst_n clears totals, windows, line position and queue; registers take their
// reset values (RGB mode, threshold 10, distance 4).
`include "image_error_statistics_core_macros.svh"

module image_error_statistics_core import iesc_pkg::*; #(
	parameter int WINDOW_LEN     = WINDOW_LEN_DEF,
	parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  iesc_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output iesc_out_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SLOT_W = $clog2(WINDOW_LEN);
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
	localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_LINE_WIDTH - 1);

	logic              color_mode_q;
	logic [THR_W-1:0]  threshold_q;
	logic [DIST_W-1:0] distance_q;

	logic              v_s1, eol_s1, eof_s1;
	logic              v_s2, eol_s2, eof_s2;
	logic [COL_W-1:0]  col_s2;
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;

	logic                accept;
	logic                line_clear_s1;
	logic                at_line_start;
	logic                push_s2;
	logic                pop;
	logic [CNT_W-1:0]    q_count;
	logic [CNT_W:0]      claim;
	iesc_lane_ctrl_t     lane_ctrl;
	iesc_lane_stat_t     lane_stat [LANES];
	logic [SAMPLE_W-1:0] ref_arr   [LANES];
	logic [SAMPLE_W-1:0] test_arr  [LANES];
	logic [SSE_W-1:0]    sse_next  [LANES];
	logic [SAMPLE_W-1:0] max_next  [LANES];
	logic [ALARM_W-1:0]  alarm_next;
	logic [LARGE_W-1:0]  large_next;
	iesc_out_t           result;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
			threshold_q  <= THRESHOLD_RESET;
			distance_q   <= DISTANCE_RESET;
		end else if (cfg_we) begin
			unique case (iesc_cfg_index_t'(cfg_index))
				CFG_COLOR_MODE:       color_mode_q <= cfg_data[0];
				CFG_WINDOW_THRESHOLD: threshold_q  <= cfg_data[THR_W-1:0];
				CFG_ALARM_DISTANCE:   distance_q   <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// hold requests while queued results plus frame ends in flight fill the queue
	assign claim    = (CNT_W+1)'(q_count) + (CNT_W+1)'(v_s1 && eof_s1)
	                + (CNT_W+1)'(v_s2 && eof_s2);
	assign in_stall = claim >= (CNT_W+1)'(OUT_DEPTH);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eol_s1 <= in_data.end_of_line;
			eof_s1 <= in_data.end_of_frame;
		end
		if (v_s1) begin
			eol_s2 <= eol_s1;
			eof_s2 <= eof_s1;
			col_s2 <= col_q;
		end
	end

	assign line_clear_s1 = eol_s1 || eof_s1;

	// line position: advance per pixel up to the last column, drop back at line or frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			slot_q <= '0;
			fill_q <= FILL_W'(1);
		end else if (v_s1) begin
			if (line_clear_s1) begin
				col_q  <= '0;
				slot_q <= '0;
				fill_q <= FILL_W'(1);
			end else if (col_q < COL_MAX) begin
				col_q  <= col_q + 1'b1;
				slot_q <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
				if (fill_q != FILL_W'(WINDOW_LEN)) fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign at_line_start = (col_q == '0) && (slot_q == '0) && (fill_q == FILL_W'(1));

	assign lane_ctrl.rgb        = !color_mode_q;
	assign lane_ctrl.line_clear = line_clear_s1;
	assign lane_ctrl.threshold  = threshold_q;

	assign ref_arr[0]  = in_data.ref_lane0;
	assign ref_arr[1]  = in_data.ref_lane1;
	assign ref_arr[2]  = in_data.ref_lane2;
	assign test_arr[0] = in_data.test_lane0;
	assign test_arr[1] = in_data.test_lane1;
	assign test_arr[2] = in_data.test_lane2;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		iesc_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.accept     (accept),
			.ref_sample (ref_arr[g]),
			.test_sample(test_arr[g]),
			.ok         (in_data.lane_valid[g]),
			.v_s1       (v_s1),
			.ctrl       (lane_ctrl),
			.slot       (slot_q),
			.fill       (fill_q),
			.v_s2       (v_s2),
			.eof_s2     (eof_s2),
			.stat_s2    (lane_stat[g]),
			.sse_next   (sse_next[g]),
			.max_next   (max_next[g])
		);
	end

	iesc_merge #(.COL_W(COL_W)) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.v_s2          (v_s2),
		.line_end_s2   (eol_s2 || eof_s2),
		.eof_s2        (eof_s2),
		.col_s2        (col_s2),
		.stat          (lane_stat),
		.alarm_distance(distance_q),
		.alarm_next    (alarm_next),
		.large_next    (large_next)
	);

	assign result.sse_lane0          = sse_next[0];
	assign result.sse_lane1          = sse_next[1];
	assign result.sse_lane2          = sse_next[2];
	assign result.max_err_lane0      = max_next[0];
	assign result.max_err_lane1      = max_next[1];
	assign result.max_err_lane2      = max_next[2];
	assign result.window_alarm_count = alarm_next;
	assign result.large_error_count  = large_next;

	assign push_s2 = v_s2 && eof_s2;
	assign pop     = out_valid && !out_stall;

	iesc_out_fifo #(.DEPTH(OUT_DEPTH)) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_s2),
		.push_data(result),
		.pop      (pop),
		.out_valid(out_valid),
		.out_data (out_data),
		.count    (q_count)
	);

	`IESC_ASSERT(a_queue_room, clk, arst_n, push_s2, (q_count < CNT_W'(OUT_DEPTH)) || pop)
	`IESC_ASSERT_NEXT(a_line_restart, clk, arst_n, v_s1 && line_clear_s1, at_line_start)
	`IESC_ASSERT(a_fill_range, clk, arst_n, 1'b1, (fill_q != '0) && (fill_q <= FILL_W'(WINDOW_LEN)))

endmodule

// ===== dv/image_error_statistics_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for image_error_statistics_core: pixel frames go in through a
// queue-fed driver, per-frame totals are predicted in-line and compared field by field.
// Depends on iesc_pkg and the core RTL only.
module image_error_statistics_core_tb import iesc_pkg::*; ();

	localparam int LINE_MAX = 64;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int TIMEOUT_NS = 5_000_000;
	localparam logic MODE_RGB = 1'b0;
	localparam logic MODE_YUV = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	iesc_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	iesc_out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_COLOR_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	iesc_in_t pixel_q[$];
	iesc_out_t pending_totals[$];
	iesc_out_t want;
	logic in_fire = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int pixels_open = 0;
	int pixels_sent = 0;
	int frames_checked = 0;
	int settings_applied = 0;
	int mismatch_count = 0;

	logic mode_yuv = MODE_RGB;
	logic [THR_W-1:0] thr = THRESHOLD_RESET;
	logic [DIST_W-1:0] gap_limit = DISTANCE_RESET;
	logic [SSE_W-1:0] sse_tot [LANES] = '{default: '0};
	logic [SAMPLE_W-1:0] peak_err [LANES] = '{default: '0};
	int win_err [LANES][WINDOW_LEN_DEF];
	int win_total [LANES] = '{default: 0};
	int col = 0;
	int last_alarm_col = 0;
	logic [ALARM_W-1:0] alarm_tot = '0;
	logic [LARGE_W-1:0] big_tot = '0;

	image_error_statistics_core #(
		.MAX_LINE_WIDTH(LINE_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic account_pixel(input iesc_in_t px);
		logic [SAMPLE_W-1:0] refs [LANES];
		logic [SAMPLE_W-1:0] tests [LANES];
		logic [SSE_W:0] grown;
		logic [ALARM_W:0] bumped;
		int slot;
		int fill;
		int err;
		int gap;
		refs = '{px.ref_lane0, px.ref_lane1, px.ref_lane2};
		tests = '{px.test_lane0, px.test_lane1, px.test_lane2};
		slot = col % WINDOW_LEN_DEF;
		fill = (col + 1 < WINDOW_LEN_DEF) ? col + 1 : WINDOW_LEN_DEF;
		for (int k = 0; k < LANES; k++) begin
			err = int'(tests[k]) - int'(refs[k]);
			if (err < 0)
				err = -err;
			if (!px.lane_valid[k]) begin
				err = 0;
			end else begin
				grown = {1'b0, sse_tot[k]} + (SSE_W+1)'(err * err);
				sse_tot[k] = grown[SSE_W] ? '1 : grown[SSE_W-1:0];
			end
			if (mode_yuv)
				continue;
			win_total[k] = win_total[k] - win_err[k][slot] + err;
			win_err[k][slot] = err;
			if (!px.lane_valid[k])
				continue;
			if (err > peak_err[k])
				peak_err[k] = SAMPLE_W'(err);
			if (err > LARGE_ERR_LIMIT && big_tot != '1)
				big_tot++;
			if (win_total[k] > thr * fill) begin
				gap = col - last_alarm_col;
				bumped = {1'b0, alarm_tot} + (ALARM_W+1)'((gap < gap_limit) ? 2 : 1);
				alarm_tot = bumped[ALARM_W] ? '1 : bumped[ALARM_W-1:0];
				last_alarm_col = col;
			end
		end
		if (col < LINE_MAX - 1)
			col++;
		if (px.end_of_line || px.end_of_frame) begin
			foreach (win_err[k, s])
				win_err[k][s] = 0;
			win_total = '{default: 0};
			col = 0;
			last_alarm_col = 0;
		end
		if (px.end_of_frame) begin
			pending_totals.push_back(iesc_out_t'{
				sse_lane0: sse_tot[0], sse_lane1: sse_tot[1], sse_lane2: sse_tot[2],
				max_err_lane0: peak_err[0], max_err_lane1: peak_err[1],
				max_err_lane2: peak_err[2], window_alarm_count: alarm_tot,
				large_error_count: big_tot});
			sse_tot = '{default: '0};
			peak_err = '{default: '0};
			alarm_tot = '0;
			big_tot = '0;
		end
	endtask

	function automatic void compare_field(input string field, input logic [SSE_W-1:0] exp_val,
			input logic [SSE_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, act_val);
			mismatch_count++;
		end
	endfunction

	// advance to the next request once the current one is taken
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= pixel_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_totals.size() == 0) begin
					$error("frame totals arrived with no frame pending");
					mismatch_count++;
				end else begin
					want = pending_totals.pop_front();
					compare_field("sse_lane0", want.sse_lane0, out_data.sse_lane0);
					compare_field("sse_lane1", want.sse_lane1, out_data.sse_lane1);
					compare_field("sse_lane2", want.sse_lane2, out_data.sse_lane2);
					compare_field("max_err_lane0", SSE_W'(want.max_err_lane0),
						SSE_W'(out_data.max_err_lane0));
					compare_field("max_err_lane1", SSE_W'(want.max_err_lane1),
						SSE_W'(out_data.max_err_lane1));
					compare_field("max_err_lane2", SSE_W'(want.max_err_lane2),
						SSE_W'(out_data.max_err_lane2));
					compare_field("window_alarm_count", SSE_W'(want.window_alarm_count),
						SSE_W'(out_data.window_alarm_count));
					compare_field("large_error_count", SSE_W'(want.large_error_count),
						SSE_W'(out_data.large_error_count));
					frames_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				account_pixel(in_data);
				pixels_open--;
			end
		end
	end

	task automatic queue_pixel(input logic [SAMPLE_W-1:0] r0, r1, r2, t0, t1, t2,
			input logic [LANES-1:0] vld, input logic eol, eof);
		pixel_q.push_back(iesc_in_t'{r0, r1, r2, t0, t1, t2, vld, eol, eof});
		pixels_open++;
		pixels_sent++;
	endtask

	task automatic queue_random_pixel(input int emax, input logic eol, eof);
		logic [SAMPLE_W-1:0] rs [LANES];
		logic [SAMPLE_W-1:0] ts [LANES];
		logic [LANES-1:0] vld;
		int err;
		for (int k = 0; k < LANES; k++) begin
			rs[k] = SAMPLE_W'($urandom);
			if (emax < 0) begin
				ts[k] = SAMPLE_W'($urandom);
			end else begin
				err = $urandom_range(emax);
				if (rs[k] >= err && (int'(rs[k]) + err > SAMPLE_MAX || $urandom_range(1)))
					ts[k] = SAMPLE_W'(int'(rs[k]) - err);
				else
					ts[k] = SAMPLE_W'(int'(rs[k]) + err);
			end
		end
		vld = ($urandom_range(99) < 80) ? '1 : LANES'($urandom);
		queue_pixel(rs[0], rs[1], rs[2], ts[0], ts[1], ts[2], vld, eol, eof);
	endtask

	task automatic queue_frame();
		int lines;
		int len;
		int emax;
		logic last_line;
		lines = $urandom_range(4, 1);
		for (int ln = 0; ln < lines; ln++) begin
			last_line = (ln == lines - 1);
			if ($urandom_range(99) < 12)
				len = $urandom_range(LINE_MAX + 16, LINE_MAX - 4);
			else
				len = $urandom_range(24, 1);
			case ($urandom_range(3))
				0: emax = 4;
				1: emax = 30;
				2: emax = 300;
				default: emax = -1;
			endcase
			for (int p = 0; p < len; p++) begin
				queue_random_pixel(emax,
					(p == len - 1) && (!last_line || $urandom_range(1)),
					(p == len - 1) && last_line);
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixels_open != 0 || pending_totals.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int count);
		int start;
		start = pixels_sent;
		while (pixels_sent - start < count)
			queue_frame();
		// sometimes leave a line open across the next register change
		if ($urandom_range(1)) begin
			repeat ($urandom_range(6, 1))
				queue_random_pixel(300, 1'b0, 1'b0);
		end
		wait_idle();
	endtask

	task automatic apply_settings(input logic mode, input logic [THR_W-1:0] th,
			input logic [DIST_W-1:0] ds);
		logic [CFG_DATA_W-1:0] word;
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_UNUSED;
		cfg_data <= CFG_DATA_W'($urandom);
		@(negedge clk);
		word = CFG_DATA_W'($urandom);
		word[0] = mode;
		cfg_index <= CFG_COLOR_MODE;
		cfg_data <= word;
		@(negedge clk);
		word = CFG_DATA_W'($urandom);
		word[THR_W-1:0] = th;
		cfg_index <= CFG_WINDOW_THRESHOLD;
		cfg_data <= word;
		@(negedge clk);
		cfg_index <= CFG_ALARM_DISTANCE;
		cfg_data <= ds;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_yuv = mode;
		thr = th;
		gap_limit = ds;
		settings_applied++;
	endtask

	initial begin
		foreach (win_err[k, s])
			win_err[k][s] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 25;
		recv_stall_pct = 75;
		queue_pixel(0, 4095, 0, 4095, 0, 4095, 3'b111, 1'b0, 1'b0);
		queue_pixel(4095, 4095, 0, 4095, 4095, 0, 3'b111, 1'b0, 1'b0);
		queue_pixel(100, 110, 200, 110, 100, 210, 3'b111, 1'b0, 1'b0);
		queue_pixel(100, 111, 200, 111, 100, 211, 3'b111, 1'b0, 1'b0);
		queue_pixel(0, 0, 0, 4095, 4095, 4095, 3'b000, 1'b0, 1'b0);
		queue_pixel(0, 0, 0, 4095, 4095, 4095, 3'b101, 1'b0, 1'b0);
		queue_pixel(0, 0, 0, 4095, 4095, 4095, 3'b010, 1'b1, 1'b0);
		repeat (10)
			queue_pixel(500, 0, 0, 550, 0, 0, 3'b001, 1'b0, 1'b0);
		queue_pixel(0, 0, 0, 200, 200, 200, 3'b111, 1'b0, 1'b0);
		queue_pixel(0, 0, 0, 0, 0, 0, 3'b111, 1'b1, 1'b1);
		queue_pixel(7, 7, 7, 3, 3, 3, 3'b111, 1'b0, 1'b1);
		wait_idle();

		apply_settings(MODE_RGB, '0, '0);
		run_phase(250);
		apply_settings(MODE_YUV, '1, '1);
		run_phase(250);

		send_idle_pct = 75;
		recv_stall_pct = 25;
		apply_settings(MODE_RGB, '1, '1);
		run_phase(250);
		apply_settings(MODE_RGB, THR_W'($urandom_range(60, 1)), DIST_W'($urandom_range(20, 1)));
		run_phase(250);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		apply_settings(MODE_YUV, THR_W'($urandom_range(60)), DIST_W'($urandom_range(20)));
		run_phase(250);
		apply_settings(MODE_RGB, THR_W'($urandom_range(60)), DIST_W'($urandom_range(20)));
		run_phase(280);

		$display("Sent %0d pixels, checked %0d frame totals under %0d register settings",
			pixels_sent, frames_checked, settings_applied);
		$display("(RGB and YUV, threshold and distance extremes, line saturation, backpressure)");
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#TIMEOUT_NS;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
